FILE: rtl/hoc_pkg.sv
package hoc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SQ_W        = PROD_W + 1;
    localparam int IN_TDATA_W  = 8 * FIELD_W;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic        [SQ_W-1:0]    t_sq;

    typedef struct packed {
        t_field lx;
        t_field ly;
        t_field rx;
        t_field ry;
        logic   dom_left;
    } t_hseg;

    typedef struct packed {
        logic decided;
        logic ahead;
    } t_verdict;

    typedef struct packed {
        t_verdict early;
        logic     equal;
        logic     dom_left;
        logic     vert_a;
        logic     vert_b;
        logic     dx_sign_differ;
        logic     pos_a;
        logic     pos_b;
    } t_ctrl;

endpackage

FILE: rtl/halfsegment_order_compare.sv
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata: A lx, ly, rx, ry, B lx, ly, rx, ry (32 b each); tuser: A, B dom-left
// m_axis   | out | tdata: bit 0 a_before_b, bit 1 a_equals_b, rest zero
//
// One beat per cycle in, one result beat per cycle out while the output is not stalled;
// four register stages lie between an input beat and its result beat.
// Stages: endpoint differences, cross and square products, slope verdict with
// squared lengths, final length compare into the output register.
// i_rst_n clears the stage valid flags only.
// A stalled output freezes the whole pipeline; s_axis_tready drops only then.
module halfsegment_order_compare (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] a_left_x, [63:32] a_left_y, [95:64] a_right_x, [127:96] a_right_y,
    // [159:128] b_left_x, [191:160] b_left_y, [223:192] b_right_x, [255:224] b_right_y
    input  logic [hoc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] a_dom_is_left, [1] b_dom_is_left
    input  logic [hoc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] a_before_b, [1] a_equals_b, [7:2] zero
    output logic [hoc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int FW = hoc_pkg::FIELD_W;

    logic              en;
    hoc_pkg::t_hseg    seg_a, seg_b;

    logic              s1_valid;
    hoc_pkg::t_ctrl    s1_ctrl;
    hoc_pkg::t_diff    s1_adx, s1_ady, s1_bdx, s1_bdy;

    logic              s2_valid;
    hoc_pkg::t_ctrl    s2_ctrl;
    hoc_pkg::t_prod    s2_cross_ab, s2_cross_ba, s2_sq_adx, s2_sq_ady, s2_sq_bdx, s2_sq_bdy;

    logic              s3_valid;
    hoc_pkg::t_verdict s3_early, s3_slope;
    logic              s3_equal;
    hoc_pkg::t_sq      s3_len_a, s3_len_b;

    logic              n_before;
    logic              r_out_valid;
    logic              r_before, r_equal;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        seg_a.lx       = s_axis_tdata[0*FW +: FW];
        seg_a.ly       = s_axis_tdata[1*FW +: FW];
        seg_a.rx       = s_axis_tdata[2*FW +: FW];
        seg_a.ry       = s_axis_tdata[3*FW +: FW];
        seg_a.dom_left = s_axis_tuser[0];
        seg_b.lx       = s_axis_tdata[4*FW +: FW];
        seg_b.ly       = s_axis_tdata[5*FW +: FW];
        seg_b.rx       = s_axis_tdata[6*FW +: FW];
        seg_b.ry       = s_axis_tdata[7*FW +: FW];
        seg_b.dom_left = s_axis_tuser[1];
    end

    hoc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_seg_a (seg_a),
        .i_seg_b (seg_b),
        .o_valid (s1_valid),
        .o_ctrl  (s1_ctrl),
        .o_adx   (s1_adx),
        .o_ady   (s1_ady),
        .o_bdx   (s1_bdx),
        .o_bdy   (s1_bdy)
    );

    hoc_mult u_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s1_valid),
        .i_ctrl     (s1_ctrl),
        .i_adx      (s1_adx),
        .i_ady      (s1_ady),
        .i_bdx      (s1_bdx),
        .i_bdy      (s1_bdy),
        .o_valid    (s2_valid),
        .o_ctrl     (s2_ctrl),
        .o_cross_ab (s2_cross_ab),
        .o_cross_ba (s2_cross_ba),
        .o_sq_adx   (s2_sq_adx),
        .o_sq_ady   (s2_sq_ady),
        .o_sq_bdx   (s2_sq_bdx),
        .o_sq_bdy   (s2_sq_bdy)
    );

    hoc_slope u_slope (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s2_valid),
        .i_ctrl     (s2_ctrl),
        .i_cross_ab (s2_cross_ab),
        .i_cross_ba (s2_cross_ba),
        .i_sq_adx   (s2_sq_adx),
        .i_sq_ady   (s2_sq_ady),
        .i_sq_bdx   (s2_sq_bdx),
        .i_sq_bdy   (s2_sq_bdy),
        .o_valid    (s3_valid),
        .o_early    (s3_early),
        .o_slope    (s3_slope),
        .o_equal    (s3_equal),
        .o_len_a    (s3_len_a),
        .o_len_b    (s3_len_b)
    );

    always_comb begin
        if (s3_early.decided) begin
            n_before = s3_early.ahead;
        end else if (s3_slope.decided) begin
            n_before = s3_slope.ahead;
        end else begin
            n_before = (s3_len_a < s3_len_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_before <= n_before;
            r_equal  <= s3_equal;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(hoc_pkg::OUT_TDATA_W-2){1'b0}}, r_equal, r_before};

    a_equal_not_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("equal half segments flagged as ordered");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3_valid && en |=> m_axis_tvalid)
        else $error("result lost between last stage and output register");

    a_early_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3_valid && s3_equal |-> !s3_early.decided && !s3_slope.decided)
        else $error("equal half segments decided before length compare");

endmodule

FILE: rtl/hoc_prep.sv
module hoc_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hoc_pkg::t_hseg    i_seg_a,
    input  hoc_pkg::t_hseg    i_seg_b,
    output logic              o_valid,
    output hoc_pkg::t_ctrl    o_ctrl,
    output hoc_pkg::t_diff    o_adx,
    output hoc_pkg::t_diff    o_ady,
    output hoc_pkg::t_diff    o_bdx,
    output hoc_pkg::t_diff    o_bdy
);

    function automatic hoc_pkg::t_diff coord_ext(hoc_pkg::t_field v);
        return hoc_pkg::t_diff'(signed'(v[hoc_pkg::COORD_WIDTH-1:0]));
    endfunction

    hoc_pkg::t_diff a_lx, a_ly, a_rx, a_ry, b_lx, b_ly, b_rx, b_ry;
    hoc_pkg::t_diff ax, ay, bx, by;
    hoc_pkg::t_diff n_adx, n_ady, n_bdx, n_bdy;
    hoc_pkg::t_ctrl n_ctrl;

    logic           r_valid;
    hoc_pkg::t_ctrl r_ctrl;
    hoc_pkg::t_diff r_adx, r_ady, r_bdx, r_bdy;

    always_comb begin
        a_lx = coord_ext(i_seg_a.lx);
        a_ly = coord_ext(i_seg_a.ly);
        a_rx = coord_ext(i_seg_a.rx);
        a_ry = coord_ext(i_seg_a.ry);
        b_lx = coord_ext(i_seg_b.lx);
        b_ly = coord_ext(i_seg_b.ly);
        b_rx = coord_ext(i_seg_b.rx);
        b_ry = coord_ext(i_seg_b.ry);

        ax = i_seg_a.dom_left ? a_lx : a_rx;
        ay = i_seg_a.dom_left ? a_ly : a_ry;
        bx = i_seg_b.dom_left ? b_lx : b_rx;
        by = i_seg_b.dom_left ? b_ly : b_ry;

        n_adx = a_rx - a_lx;
        n_ady = a_ry - a_ly;
        n_bdx = b_rx - b_lx;
        n_bdy = b_ry - b_ly;

        if (ax != bx) begin
            n_ctrl.early = '{decided: 1'b1, ahead: (ax < bx)};
        end else if (ay != by) begin
            n_ctrl.early = '{decided: 1'b1, ahead: (ay < by)};
        end else if (i_seg_a.dom_left != i_seg_b.dom_left) begin
            n_ctrl.early = '{decided: 1'b1, ahead: !i_seg_a.dom_left};
        end else begin
            n_ctrl.early = '{decided: 1'b0, ahead: 1'b0};
        end

        n_ctrl.equal = (a_lx == b_lx) && (a_ly == b_ly) && (a_rx == b_rx) &&
                       (a_ry == b_ry) && (i_seg_a.dom_left == i_seg_b.dom_left);
        n_ctrl.dom_left       = i_seg_a.dom_left;
        n_ctrl.vert_a         = (n_adx == '0);
        n_ctrl.vert_b         = (n_bdx == '0);
        n_ctrl.dx_sign_differ = n_adx[hoc_pkg::DIFF_W-1] ^ n_bdx[hoc_pkg::DIFF_W-1];
        n_ctrl.pos_a          = (n_ady != '0) &&
                                (n_ady[hoc_pkg::DIFF_W-1] == n_adx[hoc_pkg::DIFF_W-1]);
        n_ctrl.pos_b          = (n_bdy != '0) &&
                                (n_bdy[hoc_pkg::DIFF_W-1] == n_bdx[hoc_pkg::DIFF_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl <= n_ctrl;
            r_adx  <= n_adx;
            r_ady  <= n_ady;
            r_bdx  <= n_bdx;
            r_bdy  <= n_bdy;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_adx   = r_adx;
    assign o_ady   = r_ady;
    assign o_bdx   = r_bdx;
    assign o_bdy   = r_bdy;

endmodule

FILE: rtl/hoc_mult.sv
module hoc_mult (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  hoc_pkg::t_ctrl    i_ctrl,
    input  hoc_pkg::t_diff    i_adx,
    input  hoc_pkg::t_diff    i_ady,
    input  hoc_pkg::t_diff    i_bdx,
    input  hoc_pkg::t_diff    i_bdy,
    output logic              o_valid,
    output hoc_pkg::t_ctrl    o_ctrl,
    output hoc_pkg::t_prod    o_cross_ab,
    output hoc_pkg::t_prod    o_cross_ba,
    output hoc_pkg::t_prod    o_sq_adx,
    output hoc_pkg::t_prod    o_sq_ady,
    output hoc_pkg::t_prod    o_sq_bdx,
    output hoc_pkg::t_prod    o_sq_bdy
);

    logic           r_valid;
    hoc_pkg::t_ctrl r_ctrl;
    hoc_pkg::t_prod r_cross_ab, r_cross_ba, r_sq_adx, r_sq_ady, r_sq_bdx, r_sq_bdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl     <= i_ctrl;
            r_cross_ab <= hoc_pkg::t_prod'(i_ady) * hoc_pkg::t_prod'(i_bdx);
            r_cross_ba <= hoc_pkg::t_prod'(i_bdy) * hoc_pkg::t_prod'(i_adx);
            r_sq_adx   <= hoc_pkg::t_prod'(i_adx) * hoc_pkg::t_prod'(i_adx);
            r_sq_ady   <= hoc_pkg::t_prod'(i_ady) * hoc_pkg::t_prod'(i_ady);
            r_sq_bdx   <= hoc_pkg::t_prod'(i_bdx) * hoc_pkg::t_prod'(i_bdx);
            r_sq_bdy   <= hoc_pkg::t_prod'(i_bdy) * hoc_pkg::t_prod'(i_bdy);
        end
    end

    assign o_valid    = r_valid;
    assign o_ctrl     = r_ctrl;
    assign o_cross_ab = r_cross_ab;
    assign o_cross_ba = r_cross_ba;
    assign o_sq_adx   = r_sq_adx;
    assign o_sq_ady   = r_sq_ady;
    assign o_sq_bdx   = r_sq_bdx;
    assign o_sq_bdy   = r_sq_bdy;

endmodule

FILE: rtl/hoc_slope.sv
module hoc_slope (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  hoc_pkg::t_ctrl     i_ctrl,
    input  hoc_pkg::t_prod     i_cross_ab,
    input  hoc_pkg::t_prod     i_cross_ba,
    input  hoc_pkg::t_prod     i_sq_adx,
    input  hoc_pkg::t_prod     i_sq_ady,
    input  hoc_pkg::t_prod     i_sq_bdx,
    input  hoc_pkg::t_prod     i_sq_bdy,
    output logic               o_valid,
    output hoc_pkg::t_verdict  o_early,
    output hoc_pkg::t_verdict  o_slope,
    output logic               o_equal,
    output hoc_pkg::t_sq       o_len_a,
    output hoc_pkg::t_sq       o_len_b
);

    logic              cross_eq, a_lower, a_higher;
    hoc_pkg::t_verdict n_slope;

    logic              r_valid;
    hoc_pkg::t_verdict r_early, r_slope;
    logic              r_equal;
    hoc_pkg::t_sq      r_len_a, r_len_b;

    always_comb begin
        cross_eq = (i_cross_ab == i_cross_ba);
        a_lower  = !cross_eq && ((i_cross_ab < i_cross_ba) ^ i_ctrl.dx_sign_differ);
        a_higher = !cross_eq && !a_lower;

        n_slope = '{decided: 1'b0, ahead: 1'b0};
        if (i_ctrl.dom_left) begin
            if (i_ctrl.vert_b && !i_ctrl.vert_a) begin
                n_slope = '{decided: 1'b1, ahead: i_ctrl.pos_a};
            end else if (i_ctrl.vert_a && !i_ctrl.vert_b) begin
                n_slope = '{decided: 1'b1, ahead: !i_ctrl.pos_b};
            end else if (!i_ctrl.vert_a && !cross_eq) begin
                n_slope = '{decided: 1'b1, ahead: a_lower};
            end
        end else begin
            if (i_ctrl.vert_b && !i_ctrl.vert_a) begin
                n_slope = '{decided: 1'b1, ahead: 1'b1};
            end else if (i_ctrl.vert_a && !i_ctrl.vert_b) begin
                n_slope = '{decided: 1'b1, ahead: 1'b0};
            end else if (!i_ctrl.vert_a && !cross_eq) begin
                n_slope = '{decided: 1'b1, ahead: a_higher};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_early <= i_ctrl.early;
            r_slope <= n_slope;
            r_equal <= i_ctrl.equal;
            r_len_a <= hoc_pkg::t_sq'(unsigned'(i_sq_adx)) +
                       hoc_pkg::t_sq'(unsigned'(i_sq_ady));
            r_len_b <= hoc_pkg::t_sq'(unsigned'(i_sq_bdx)) +
                       hoc_pkg::t_sq'(unsigned'(i_sq_bdy));
        end
    end

    assign o_valid = r_valid;
    assign o_early = r_early;
    assign o_slope = r_slope;
    assign o_equal = r_equal;
    assign o_len_a = r_len_a;
    assign o_len_b = r_len_b;

endmodule
